// File: rtl/gpws_pkg.sv
// gpws_pkg: shared types and constants for the grid path waypoint simplifier
// item and waypoint beat structs, sequencer states, map control struct
// no dependencies
package gpws_pkg;

  localparam int COORD_W = 7;

  localparam logic KIND_MAP  = 1'b0;
  localparam logic KIND_NODE = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   kind;
    coord_t x;
    coord_t y;
    logic   blocked;
    logic   first;
    logic   last;
  } item_t;

  typedef struct packed {
    coord_t waypoint_x;
    coord_t waypoint_y;
    logic   final_res;
  } waypoint_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wr_bit;
    logic mask_ld;
  } map_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_RD,
    S_MAP_WR,
    S_SETUP,
    S_SCAN,
    S_EMIT_WP,
    S_EMIT_GOAL
  } state_t;

endpackage

// File: rtl/gpws_ram.sv
// gpws_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module gpws_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/gpws_map.sv
// gpws_map: obstacle map row store with per-row valid bits, cell read-modify-write
// and the shared row check unit (column mask and hit detect); uses gpws_pkg, gpws_ram
module gpws_map #(
  parameter int GRID_DIM = 128,
  parameter int EW = 8,
  localparam int AW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  gpws_pkg::map_ctl_t ctl,
  input  logic [AW-1:0]      row,
  input  logic [AW-1:0]      col,
  input  logic [EW-1:0]      lo,
  input  logic [EW-1:0]      hi,
  output logic               hit
);

  logic [GRID_DIM-1:0] row_valid;
  logic [GRID_DIM-1:0] mask;
  logic [GRID_DIM-1:0] rdata;
  logic [GRID_DIM-1:0] cur;
  logic [GRID_DIM-1:0] wdata;
  logic                rvalid;

  gpws_ram #(
    .WIDTH(GRID_DIM),
    .DEPTH(GRID_DIM)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.wr),
    .waddr(row),
    .wdata(wdata),
    .re   (ctl.rd),
    .raddr(row),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctl.wr) begin
      row_valid[row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rvalid <= row_valid[row];
    end
  end

  // column window of the bounding rectangle
  always_ff @(posedge clk) begin
    if (ctl.mask_ld) begin
      for (int c = 0; c < GRID_DIM; c++) begin
        mask[c] <= (EW'(c) >= lo) && (EW'(c) <= hi);
      end
    end
  end

  assign cur = rvalid ? rdata : '0;

  always_comb begin
    for (int c = 0; c < GRID_DIM; c++) begin
      wdata[c] = (AW'(c) == col) ? ctl.wr_bit : cur[c];
    end
  end

  assign hit = |(cur & mask);

endmodule

// File: rtl/grid_path_waypoint_simplifier.sv
// a map write reads the row, then writes it back with the cell updated; a first node
// goes straight to the waypoint emit; a later node loads the column mask, then scans
// the rows of its bounding box in y, one row per cycle on the single map read port,
// before the decision; new items are stalled until the sequencer is back in idle
// reset: control, anchor and last clear point cleared; map rows read clear through
// per-row valid bits, so there is no clearing pass
module grid_path_waypoint_simplifier #(
  parameter int GRID_DIM = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  gpws_pkg::item_t     item,
  input  logic                item_valid,
  output logic                item_stall,
  output gpws_pkg::waypoint_t waypoint,
  output logic                waypoint_valid,
  input  logic                waypoint_stall
);

  localparam int AW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int DIM_W = $clog2(GRID_DIM + 1);
  localparam int EW    = (DIM_W > gpws_pkg::COORD_W) ? DIM_W : gpws_pkg::COORD_W;
  localparam logic [EW-1:0] DIM     = EW'(GRID_DIM);
  localparam logic [EW-1:0] DIM_MAX = EW'(GRID_DIM - 1);

  gpws_pkg::state_t state, state_next;

  gpws_pkg::coord_t node_x, node_y, anchor_x, anchor_y, lc_x, lc_y, wp_x, wp_y;
  logic             node_last;
  logic             wr_bit;
  logic [EW-1:0]    x0, x1, y0, y1, row;
  logic             chk;

  logic             fire;
  logic [EW-1:0]    ix, iy, ax, ay, hx, hy, lx, ly;
  logic             in_range;
  logic             scan_issue, scan_blk, scan_done;
  logic             out_free, out_load;
  gpws_pkg::waypoint_t out_data;
  gpws_pkg::map_ctl_t  ctl;
  logic [AW-1:0]    map_row;
  logic             hit;

  assign item_stall = (state != gpws_pkg::S_IDLE);
  assign fire       = item_valid && !item_stall;

  // bounding box against the current anchor
  assign ix = EW'(item.x);
  assign iy = EW'(item.y);
  assign ax = EW'(anchor_x);
  assign ay = EW'(anchor_y);
  assign lx = (ix < ax) ? ix : ax;
  assign ly = (iy < ay) ? iy : ay;
  assign hx = (ix < ax) ? ax : ix;
  assign hy = (iy < ay) ? ay : iy;
  assign in_range = (ix < DIM) && (iy < DIM);

  assign scan_issue = (row <= y1);
  assign scan_blk   = chk && hit;
  assign scan_done  = !scan_issue && !chk;
  assign out_free   = !waypoint_valid || !waypoint_stall;

  assign map_row = (state == gpws_pkg::S_SCAN) ? row[AW-1:0] : AW'(node_y);

  gpws_map #(
    .GRID_DIM(GRID_DIM),
    .EW      (EW)
  ) u_map (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .row(map_row),
    .col(AW'(node_x)),
    .lo (x0),
    .hi (x1),
    .hit(hit)
  );

  always_comb begin
    state_next = state;
    case (state)
      gpws_pkg::S_IDLE: begin
        if (fire) begin
          if (item.kind == gpws_pkg::KIND_MAP) begin
            state_next = in_range ? gpws_pkg::S_MAP_RD : gpws_pkg::S_IDLE;
          end else if (item.first) begin
            state_next = gpws_pkg::S_EMIT_WP;
          end else begin
            state_next = gpws_pkg::S_SETUP;
          end
        end
      end
      gpws_pkg::S_MAP_RD: state_next = gpws_pkg::S_MAP_WR;
      gpws_pkg::S_MAP_WR: state_next = gpws_pkg::S_IDLE;
      gpws_pkg::S_SETUP:  state_next = gpws_pkg::S_SCAN;
      gpws_pkg::S_SCAN: begin
        if (scan_blk) begin
          state_next = gpws_pkg::S_EMIT_WP;
        end else if (scan_done) begin
          state_next = node_last ? gpws_pkg::S_EMIT_GOAL : gpws_pkg::S_IDLE;
        end
      end
      gpws_pkg::S_EMIT_WP: begin
        if (out_free) begin
          state_next = node_last ? gpws_pkg::S_EMIT_GOAL : gpws_pkg::S_IDLE;
        end
      end
      gpws_pkg::S_EMIT_GOAL: begin
        if (out_free) begin
          state_next = gpws_pkg::S_IDLE;
        end
      end
      default: state_next = gpws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.rd      = (state == gpws_pkg::S_MAP_RD) || ((state == gpws_pkg::S_SCAN) && scan_issue);
    ctl.wr      = (state == gpws_pkg::S_MAP_WR);
    ctl.wr_bit  = wr_bit;
    ctl.mask_ld = (state == gpws_pkg::S_SETUP);
    out_load    = (state inside {gpws_pkg::S_EMIT_WP, gpws_pkg::S_EMIT_GOAL}) && out_free;
    if (state == gpws_pkg::S_EMIT_GOAL) begin
      out_data = '{waypoint_x: node_x, waypoint_y: node_y, final_res: 1'b1};
    end else begin
      out_data = '{waypoint_x: wp_x, waypoint_y: wp_y, final_res: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gpws_pkg::S_IDLE;
      anchor_x <= '0;
      anchor_y <= '0;
      lc_x     <= '0;
      lc_y     <= '0;
      chk      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        gpws_pkg::S_IDLE: begin
          if (fire) begin
            node_x    <= item.x;
            node_y    <= item.y;
            node_last <= item.last;
            wr_bit    <= item.blocked;
            x0        <= lx;
            y0        <= ly;
            x1        <= (hx >= DIM) ? DIM_MAX : hx;
            y1        <= (hy >= DIM) ? DIM_MAX : hy;
            if ((item.kind == gpws_pkg::KIND_NODE) && item.first) begin
              anchor_x <= item.x;
              anchor_y <= item.y;
              lc_x     <= item.x;
              lc_y     <= item.y;
              wp_x     <= item.x;
              wp_y     <= item.y;
            end
          end
        end
        gpws_pkg::S_SETUP: begin
          row <= y0;
          chk <= 1'b0;
        end
        gpws_pkg::S_SCAN: begin
          if (scan_issue) begin
            row <= row + 1'b1;
          end
          chk <= scan_issue;
          if (scan_blk) begin
            // re-anchor on the last clear point
            wp_x     <= lc_x;
            wp_y     <= lc_y;
            anchor_x <= lc_x;
            anchor_y <= lc_y;
            lc_x     <= node_x;
            lc_y     <= node_y;
            chk      <= 1'b0;
          end else if (scan_done) begin
            lc_x <= node_x;
            lc_y <= node_y;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_valid <= 1'b0;
    end else if (out_load) begin
      waypoint_valid <= 1'b1;
    end else if (!waypoint_stall) begin
      waypoint_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      waypoint <= out_data;
    end
  end

  a_map_rmw: assert property (@(posedge clk) disable iff (rst)
    state == gpws_pkg::S_MAP_RD |=> state == gpws_pkg::S_MAP_WR)
    else $error("map read not followed by write");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == gpws_pkg::S_SCAN) && !scan_issue && !chk |=> state != gpws_pkg::S_SCAN)
    else $error("scan did not finish");

  a_goal_last: assert property (@(posedge clk) disable iff (rst)
    state == gpws_pkg::S_EMIT_GOAL |-> node_last)
    else $error("goal beat without last node");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(waypoint_valid) |->
      $past(state == gpws_pkg::S_EMIT_WP || state == gpws_pkg::S_EMIT_GOAL))
    else $error("waypoint beat without emit state");

endmodule

// File: tb/gpws_checker.sv
// gpws_checker: watches the item and waypoint channels of the waypoint simplifier,
// keeps its own obstacle map and anchor state, and compares every waypoint beat
// depends on gpws_pkg
module gpws_checker #(
  parameter int GRID_DIM = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  gpws_pkg::item_t     item,
  input  logic                item_valid,
  input  logic                item_stall,
  input  gpws_pkg::waypoint_t waypoint,
  input  logic                waypoint_valid,
  input  logic                waypoint_stall,
  output int                  errors,
  output int                  waypoints_owed
);

  bit [GRID_DIM-1:0]   obstacle_rows [GRID_DIM];
  gpws_pkg::coord_t    anchor_x, anchor_y;
  gpws_pkg::coord_t    clear_x, clear_y;
  gpws_pkg::waypoint_t owed_waypoints [$];

  initial begin
    errors = 0;
    waypoints_owed = 0;
  end

  function automatic bit box_clear(int ax, int ay, int bx, int by);
    int x0, x1, y0, y1;
    x0 = (ax < bx) ? ax : bx;
    x1 = (ax < bx) ? bx : ax;
    y0 = (ay < by) ? ay : by;
    y1 = (ay < by) ? by : ay;
    if (x1 >= GRID_DIM) x1 = GRID_DIM - 1;
    if (y1 >= GRID_DIM) y1 = GRID_DIM - 1;
    for (int r = y0; r <= y1; r++) begin
      for (int c = x0; c <= x1; c++) begin
        if (obstacle_rows[r][c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic simplify_item(input gpws_pkg::item_t it);
    if (it.kind == gpws_pkg::KIND_MAP) begin
      if (it.x < GRID_DIM && it.y < GRID_DIM) obstacle_rows[it.y][it.x] = it.blocked;
      return;
    end
    if (it.first) begin
      anchor_x = it.x;
      anchor_y = it.y;
      clear_x  = it.x;
      clear_y  = it.y;
      owed_waypoints.push_back('{waypoint_x: it.x, waypoint_y: it.y, final_res: 1'b0});
    end else if (box_clear(int'(anchor_x), int'(anchor_y), int'(it.x), int'(it.y))) begin
      clear_x = it.x;
      clear_y = it.y;
    end else begin
      // blocked: re-anchor on the last clear point
      owed_waypoints.push_back('{waypoint_x: clear_x, waypoint_y: clear_y, final_res: 1'b0});
      anchor_x = clear_x;
      anchor_y = clear_y;
      clear_x  = it.x;
      clear_y  = it.y;
    end
    if (it.last)
      owed_waypoints.push_back('{waypoint_x: it.x, waypoint_y: it.y, final_res: 1'b1});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_DIM; r++) obstacle_rows[r] = '0;
      anchor_x = '0;
      anchor_y = '0;
      clear_x  = '0;
      clear_y  = '0;
      owed_waypoints.delete();
    end else begin
      if (item_valid && !item_stall) simplify_item(item);
      if (waypoint_valid && !waypoint_stall) begin
        if (owed_waypoints.size() == 0) begin
          $display("%0t: waypoint expected none, got x=%0d y=%0d final=%0b", $time,
                   waypoint.waypoint_x, waypoint.waypoint_y, waypoint.final_res);
          errors++;
        end else begin
          gpws_pkg::waypoint_t want;
          want = owed_waypoints.pop_front();
          if (waypoint.waypoint_x !== want.waypoint_x ||
              waypoint.waypoint_y !== want.waypoint_y ||
              waypoint.final_res !== want.final_res) begin
            $display("%0t: waypoint expected x=%0d y=%0d final=%0b, got x=%0d y=%0d final=%0b",
                     $time, want.waypoint_x, want.waypoint_y, want.final_res,
                     waypoint.waypoint_x, waypoint.waypoint_y, waypoint.final_res);
            errors++;
          end
        end
      end
    end
    waypoints_owed = owed_waypoints.size();
  end

endmodule

// File: tb/tb_top.sv
// tb_top: drives map writes and grid paths into the waypoint simplifier with random
// idling on both channels and reports the verdict
// depends on gpws_pkg, grid_path_waypoint_simplifier and gpws_checker
module tb_top;

  localparam int GRID_DIM    = 128;
  localparam int ITEM_COUNT  = 2000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEM_W      = $bits(gpws_pkg::item_t);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  gpws_pkg::item_t     item = '0;
  logic                item_valid = 1'b0;
  logic                item_stall;
  gpws_pkg::waypoint_t waypoint;
  logic                waypoint_valid;
  logic                waypoint_stall = 1'b0;

  int tx_idle_pct = 34;
  int rx_idle_pct = 79;
  int sent = 0;
  int cycles = 0;
  int errors;
  int waypoints_owed;

  always #4 clk = ~clk;

  grid_path_waypoint_simplifier #(.GRID_DIM(GRID_DIM)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .waypoint       (waypoint),
    .waypoint_valid (waypoint_valid),
    .waypoint_stall (waypoint_stall)
  );

  gpws_checker #(.GRID_DIM(GRID_DIM)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .waypoint       (waypoint),
    .waypoint_valid (waypoint_valid),
    .waypoint_stall (waypoint_stall),
    .errors         (errors),
    .waypoints_owed (waypoints_owed)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) waypoint_stall <= ($urandom_range(99) < rx_idle_pct);

  function automatic gpws_pkg::item_t mk(logic kind, int x, int y, logic blocked,
                                         logic first, logic last);
    gpws_pkg::item_t it;
    it.kind    = kind;
    it.x       = gpws_pkg::coord_t'(x);
    it.y       = gpws_pkg::coord_t'(y);
    it.blocked = blocked;
    it.first   = first;
    it.last    = last;
    return it;
  endfunction

  // random offset around c, clamped to the grid
  function automatic int near(int c, int span);
    int v;
    v = c + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > GRID_DIM - 1) v = GRID_DIM - 1;
    return v;
  endfunction

  // entered and left at a falling edge; valid stays high into the next beat
  task automatic send_beat(input gpws_pkg::item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  initial begin
    logic [ITEM_W-1:0] raw;
    int                pick, len, cx, cy, px, py;
    logic              keep_first, keep_last;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // node with no path started, against the reset anchor
    send_beat(mk(gpws_pkg::KIND_NODE, 5, 5, 1'b0, 1'b0, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 127, 127, 1'b1, 1'b0, 1'b1));
    // map writes, path flags ignored
    send_beat(mk(gpws_pkg::KIND_MAP, 0, 0, 1'b1, 1'b1, 1'b1));
    send_beat(mk(gpws_pkg::KIND_MAP, 127, 127, 1'b1, 1'b0, 1'b0));
    send_beat(mk(gpws_pkg::KIND_MAP, 12, 12, 1'b1, 1'b0, 1'b0));
    // first and last together
    send_beat(mk(gpws_pkg::KIND_NODE, 0, 0, 1'b0, 1'b1, 1'b1));
    // clear step, blocked step, blocked on the goal
    send_beat(mk(gpws_pkg::KIND_NODE, 10, 10, 1'b0, 1'b1, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 11, 11, 1'b1, 1'b0, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 13, 13, 1'b0, 1'b0, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 127, 127, 1'b0, 1'b0, 1'b1));
    send_beat(mk(gpws_pkg::KIND_NODE, 127, 127, 1'b0, 1'b1, 1'b1));
    send_beat(mk(gpws_pkg::KIND_NODE, 127, 0, 1'b0, 1'b0, 1'b0));
    send_beat(mk(gpws_pkg::KIND_MAP, 127, 127, 1'b0, 1'b1, 1'b0));
    send_beat(mk(gpws_pkg::KIND_MAP, 0, 0, 1'b0, 1'b0, 1'b1));
    // full-map boxes
    send_beat(mk(gpws_pkg::KIND_NODE, 0, 127, 1'b0, 1'b1, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 127, 0, 1'b0, 1'b0, 1'b1));
    send_beat(mk(gpws_pkg::KIND_MAP, 12, 12, 1'b0, 1'b0, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 0, 0, 1'b0, 1'b1, 1'b0));
    send_beat(mk(gpws_pkg::KIND_NODE, 127, 127, 1'b1, 1'b0, 1'b1));

    while (sent < ITEM_COUNT) begin
      if (sent >= 2 * ITEM_COUNT / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (sent >= ITEM_COUNT / 3) begin
        tx_idle_pct = 79;
        rx_idle_pct = 34;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: fully random beats
        repeat ($urandom_range(1, 3)) begin
          raw = ITEM_W'($urandom);
          send_beat(gpws_pkg::item_t'(raw));
        end
      end else begin
        cx = $urandom_range(GRID_DIM - 1);
        cy = $urandom_range(GRID_DIM - 1);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(9) < 7)
            send_beat(mk(gpws_pkg::KIND_MAP, near(cx, 12), near(cy, 12),
                         $urandom_range(3) != 0,
                         1'($urandom_range(1)), 1'($urandom_range(1))));
          else
            send_beat(mk(gpws_pkg::KIND_MAP, $urandom_range(GRID_DIM - 1),
                         $urandom_range(GRID_DIM - 1), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1))));
        end
        len        = $urandom_range(1, 12);
        keep_first = ($urandom_range(19) != 0);
        keep_last  = ($urandom_range(19) != 0);
        px = near(cx, 6);
        py = near(cy, 6);
        for (int k = 0; k < len; k++) begin
          if (k > 0) begin
            if ($urandom_range(19) == 0) begin
              px = $urandom_range(GRID_DIM - 1);
              py = $urandom_range(GRID_DIM - 1);
            end else begin
              px = near(px, 4);
              py = near(py, 4);
            end
          end
          send_beat(mk(gpws_pkg::KIND_NODE, px, py, 1'($urandom_range(1)),
                       keep_first && k == 0, keep_last && k == len - 1));
        end
      end
    end
    item_valid <= 1'b0;

    while (waypoints_owed != 0) @(negedge clk);
    repeat (GRID_DIM + 16) @(negedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/gpws_pkg.sv
rtl/gpws_ram.sv
rtl/gpws_map.sv
rtl/grid_path_waypoint_simplifier.sv
tb/gpws_checker.sv
tb/tb_top.sv
